// ===== hdl/tsyn_pkg.sv =====
// ----------------------------------------------------------------------------
// tsyn_pkg
// Shared types and constants for the IPv4/TCP SYN header builder.
// ----------------------------------------------------------------------------
`default_nettype none

package tsyn_pkg;

  localparam int unsigned NUM_WORDS = 10;
  localparam int unsigned IDX_W     = 4;
  localparam int unsigned ACC_W     = 20;
  localparam int unsigned ADDR_SUM_W = 18;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_WORDS - 1);

  // configuration register indexes
  localparam logic [1:0] CFG_IP_IDENT = 2'd0;
  localparam logic [1:0] CFG_TTL      = 2'd1;
  localparam logic [1:0] CFG_DEF_WIN  = 2'd2;

  localparam logic [15:0] IDENT_RST   = 16'd54321;
  localparam logic [7:0]  TTL_RST     = 8'd64;
  localparam logic [15:0] DEF_WIN_RST = 16'hFFFF;

  localparam logic [7:0]  IP_VER_IHL = 8'h45;
  localparam logic [15:0] HDR_TOTAL  = 16'd40;
  localparam logic [7:0]  PROTO_TCP  = 8'd6;
  localparam logic [15:0] TCP_LEN    = 16'd20;
  localparam logic [3:0]  TCP_DOFF   = 4'd5;

  localparam logic [31:0] WORD0 = {IP_VER_IHL, 8'h00, HDR_TOTAL};

  typedef struct packed {
    logic [31:0] src;
    logic [31:0] dst;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [31:0] seq;
    logic [5:0]  flg;
    logic [15:0] win;
    logic [15:0] ident;
    logic [7:0]  ttl;
  } req_t;

  typedef struct packed {
    req_t                  req;
    logic [ADDR_SUM_W-1:0] addr_sum;
  } s1_t;

  typedef struct packed {
    req_t             req;
    logic [ACC_W-1:0] ip_acc;
    logic [ACC_W-1:0] tcp_acc;
  } s2_t;

  typedef struct packed {
    req_t        req;
    logic [15:0] ip_csum;
    logic [15:0] tcp_csum;
  } hdr_t;

  // end-around carry fold and complement
  function automatic logic [15:0] finish_sum(input logic [ACC_W-1:0] acc);
    logic [16:0] f1;
    logic [15:0] f2;
    f1 = {13'd0, acc[ACC_W-1:16]} + {1'b0, acc[15:0]};
    f2 = f1[15:0] + {15'd0, f1[16]};
    return ~f2;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/tsyn_hdr_pipe.sv =====
// ----------------------------------------------------------------------------
// tsyn_hdr_pipe
// Three-stage checksum pipeline: capture and address sum, header sums, fold.
// ----------------------------------------------------------------------------
`default_nettype none

module tsyn_hdr_pipe
  import tsyn_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        up_valid,
  output logic             up_ready,
  input  wire req_t        up_req,
  output logic             dn_valid,
  input  wire logic        dn_ready,
  output hdr_t             dn_hdr
);

  logic v1_r, v2_r, v3_r;
  s1_t  s1_r, s1_nxt;
  s2_t  s2_r, s2_nxt;
  hdr_t s3_r, s3_nxt;
  logic adv1, adv2, adv3;

  assign adv3     = !v3_r || dn_ready;
  assign adv2     = !v2_r || adv3;
  assign adv1     = !v1_r || adv2;
  assign up_ready = adv1;
  assign dn_valid = v3_r;
  assign dn_hdr   = s3_r;

  always_comb begin
    s1_nxt.req      = up_req;
    s1_nxt.addr_sum = ADDR_SUM_W'(up_req.src[31:16]) + ADDR_SUM_W'(up_req.src[15:0])
                    + ADDR_SUM_W'(up_req.dst[31:16]) + ADDR_SUM_W'(up_req.dst[15:0]);
  end

  always_comb begin
    s2_nxt.req    = s1_r.req;
    s2_nxt.ip_acc = ACC_W'(s1_r.addr_sum) + ACC_W'({IP_VER_IHL, 8'h00}) + ACC_W'(HDR_TOTAL)
                  + ACC_W'(s1_r.req.ident) + ACC_W'({s1_r.req.ttl, PROTO_TCP});
    // pseudo-header adds protocol and TCP length on top of the addresses
    s2_nxt.tcp_acc = ACC_W'(s1_r.addr_sum) + ACC_W'(PROTO_TCP) + ACC_W'(TCP_LEN)
                   + ACC_W'(s1_r.req.sport) + ACC_W'(s1_r.req.dport)
                   + ACC_W'(s1_r.req.seq[31:16]) + ACC_W'(s1_r.req.seq[15:0])
                   + ACC_W'({TCP_DOFF, 6'd0, s1_r.req.flg}) + ACC_W'(s1_r.req.win);
  end

  always_comb begin
    s3_nxt.req      = s2_r.req;
    s3_nxt.ip_csum  = finish_sum(s2_r.ip_acc);
    s3_nxt.tcp_csum = finish_sum(s2_r.tcp_acc);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= up_valid;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && up_valid) s1_r <= s1_nxt;
    if (adv2 && v1_r)     s2_r <= s2_nxt;
    if (adv3 && v2_r)     s3_r <= s3_nxt;
  end

endmodule

`default_nettype wire

// ===== hdl/tsyn_word_ser.sv =====
// ----------------------------------------------------------------------------
// tsyn_word_ser
// Holds one finished header and sends it out as ten 32-bit words.
// ----------------------------------------------------------------------------
`default_nettype none

module tsyn_word_ser
  import tsyn_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             up_valid,
  output logic                  up_ready,
  input  wire hdr_t             up_hdr,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [31:0]           out_word,
  output logic [IDX_W-1:0]      out_idx,
  output logic                  out_last
);

  hdr_t             hdr_r;
  logic             valid_r, valid_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             take, load, is_last;

  assign is_last  = (idx_r == LAST_IDX);
  assign take     = valid_r && out_ready;
  assign up_ready = !valid_r || (out_ready && is_last);
  assign load     = up_valid && up_ready;

  assign out_valid = valid_r;
  assign out_idx   = idx_r;
  assign out_last  = is_last;

  always_comb begin
    unique case (idx_r)
      4'd0:    out_word = WORD0;
      4'd1:    out_word = {hdr_r.req.ident, 16'h0000};
      4'd2:    out_word = {hdr_r.req.ttl, PROTO_TCP, hdr_r.ip_csum};
      4'd3:    out_word = hdr_r.req.src;
      4'd4:    out_word = hdr_r.req.dst;
      4'd5:    out_word = {hdr_r.req.sport, hdr_r.req.dport};
      4'd6:    out_word = hdr_r.req.seq;
      4'd8:    out_word = {TCP_DOFF, 6'd0, hdr_r.req.flg, hdr_r.req.win};
      4'd9:    out_word = {hdr_r.tcp_csum, 16'h0000};
      default: out_word = 32'h0000_0000;  // ack number and unused codes
    endcase
  end

  always_comb begin
    valid_nxt = valid_r;
    idx_nxt   = idx_r;
    priority if (load) begin
      valid_nxt = 1'b1;
      idx_nxt   = '0;
    end else if (take && is_last) begin
      valid_nxt = 1'b0;
    end else if (take) begin
      idx_nxt = idx_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) hdr_r <= up_hdr;
  end

endmodule

`default_nettype wire

// ===== hdl/tcp_syn_packet_builder.sv =====
// ----------------------------------------------------------------------------
// tcp_syn_packet_builder
// IPv4 + TCP header generator with Internet checksums.
// ----------------------------------------------------------------------------
// Each accepted request comes out as a 40-byte header: ten 32-bit big-endian
// words, word 0 first, out_word_index counting 0..9 and out_last_word high on
// word 9. The request passes a three-stage pipeline (capture plus address
// sum, IPv4 and pseudo-header sums, carry fold and complement), then a word
// serializer that holds one header. The output port sends one word per cycle
// while out_ready is high; the first word of a request appears once it has
// passed the pipeline registers and been loaded into the serializer. While a
// header is being sent, up to three more requests sit in the pipeline, and the
// next header, if it waits at the pipeline output, follows with no gap.
// A zero window selects default_window. Checksums of zero are sent as zero.
// Config writes (cfg_ready is always high) must come only while the block
// is idle; index 3 is ignored.
// ----------------------------------------------------------------------------
`default_nettype none

module tcp_syn_packet_builder
  import tsyn_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // request channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] in_source_addr,
  input  wire logic [31:0] in_dest_addr,
  input  wire logic [15:0] in_source_port,
  input  wire logic [15:0] in_dest_port,
  input  wire logic [31:0] in_sequence_number,
  input  wire logic [5:0]  in_flag_bits,
  input  wire logic [15:0] in_window_size,
  // header word channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_header_word,
  output logic [3:0]       out_word_index,
  output logic             out_last_word,
  // config write channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  logic [15:0] ident_r;
  logic [7:0]  ttl_r;
  logic [15:0] def_win_r;

  req_t req;
  hdr_t hdr;
  logic hdr_valid, hdr_ready;

  assign cfg_ready = 1'b1;

  // config registers; writes must come only while idle (the block itself does
  // not enforce this), so the pipeline samples them live at capture
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ident_r   <= IDENT_RST;
      ttl_r     <= TTL_RST;
      def_win_r <= DEF_WIN_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_IP_IDENT: ident_r   <= cfg_data;
        CFG_TTL:      ttl_r     <= cfg_data[7:0];
        CFG_DEF_WIN:  def_win_r <= cfg_data;
        default:      ;  // out-of-list index: dropped
      endcase
    end
  end

  always_comb begin
    req.src   = in_source_addr;
    req.dst   = in_dest_addr;
    req.sport = in_source_port;
    req.dport = in_dest_port;
    req.seq   = in_sequence_number;
    req.flg   = in_flag_bits;
    // zero window means "use the default", even if the default is zero
    req.win   = (in_window_size == 16'd0) ? def_win_r : in_window_size;
    req.ident = ident_r;
    req.ttl   = ttl_r;
  end

  tsyn_hdr_pipe u_pipe (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .up_req   (req),
    .dn_valid (hdr_valid),
    .dn_ready (hdr_ready),
    .dn_hdr   (hdr)
  );

  tsyn_word_ser u_ser (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (hdr_valid),
    .up_ready  (hdr_ready),
    .up_hdr    (hdr),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_header_word),
    .out_idx   (out_word_index),
    .out_last  (out_last_word)
  );

  // a header never breaks up: a non-final word is followed by the next one
  a_word_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_word |=>
      out_valid && (out_word_index == $past(out_word_index) + 4'd1))
    else $error("header word sequence broken");

  // word 0 is the fixed version/length word
  a_word0: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_word_index == 4'd0) |-> out_header_word == WORD0)
    else $error("bad first header word");

  // with nothing on the output the whole pipe can take a request
  a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled while output is empty");

  // an index never runs past the last word
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_word_index <= LAST_IDX))
    else $error("word index out of range");

endmodule

`default_nettype wire

// ===== test/tsyn_checker.sv =====
// ----------------------------------------------------------------------------
// tsyn_checker
// Watches the request, header word and config channels of the SYN header
// builder. It rebuilds the ten header words for every accepted request
// and compares each accepted word, field by field, with the oldest
// expected word.
// ----------------------------------------------------------------------------
`default_nettype none

module tsyn_checker
  import tsyn_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic [31:0] in_source_addr,
  input  wire logic [31:0] in_dest_addr,
  input  wire logic [15:0] in_source_port,
  input  wire logic [15:0] in_dest_port,
  input  wire logic [31:0] in_sequence_number,
  input  wire logic [5:0]  in_flag_bits,
  input  wire logic [15:0] in_window_size,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic [31:0] out_header_word,
  input  wire logic [3:0]  out_word_index,
  input  wire logic        out_last_word,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  output int               err_count,
  output int               pending
);

  typedef struct packed {
    logic [31:0] word;
    logic [3:0]  idx;
    logic        last;
  } hdr_beat_t;

  hdr_beat_t   expected_words[$];
  hdr_beat_t   exp_beat;
  logic [9:0][31:0] hdr;

  // shadow copy of the config registers
  logic [15:0] cur_ident   = IDENT_RST;
  logic [7:0]  cur_ttl     = TTL_RST;
  logic [15:0] cur_def_win = DEF_WIN_RST;

  initial begin
    err_count = 0;
    pending   = 0;
  end

  function automatic logic [31:0] halves(input logic [31:0] w);
    return {16'd0, w[31:16]} + {16'd0, w[15:0]};
  endfunction

  // end-around carry, then complement
  function automatic logic [15:0] ones_fold(input logic [31:0] total);
    logic [31:0] t;
    t = {16'd0, total[31:16]} + {16'd0, total[15:0]};
    t = t + {16'd0, t[31:16]};
    return ~t[15:0];
  endfunction

  function automatic logic [9:0][31:0] build_header(
    input logic [31:0] src,
    input logic [31:0] dst,
    input logic [15:0] sport,
    input logic [15:0] dport,
    input logic [31:0] seq,
    input logic [5:0]  flg,
    input logic [15:0] win
  );
    logic [9:0][31:0] w;
    logic [31:0]      total;
    logic [15:0]      eff_win;
    eff_win = (win == 16'd0) ? cur_def_win : win;
    w[0] = {IP_VER_IHL, 8'h00, HDR_TOTAL};
    w[1] = {cur_ident, 16'h0000};
    w[2] = {cur_ttl, PROTO_TCP, 16'h0000};
    w[3] = src;
    w[4] = dst;
    w[5] = {sport, dport};
    w[6] = seq;
    w[7] = 32'd0;
    w[8] = {TCP_DOFF, 6'd0, flg, eff_win};
    w[9] = 32'd0;
    total = 32'd0;
    for (int i = 0; i < 5; i++) total = total + halves(w[i]);
    w[2][15:0] = ones_fold(total);
    // pseudo-header, then the TCP words with the checksum at zero
    total = halves(src) + halves(dst) + halves({8'd0, PROTO_TCP, TCP_LEN});
    for (int i = 5; i < 10; i++) total = total + halves(w[i]);
    w[9] = {ones_fold(total), 16'h0000};
    return w;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      cur_ident   = IDENT_RST;
      cur_ttl     = TTL_RST;
      cur_def_win = DEF_WIN_RST;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_IP_IDENT: cur_ident   = cfg_data;
          CFG_TTL:      cur_ttl     = cfg_data[7:0];
          CFG_DEF_WIN:  cur_def_win = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        hdr = build_header(in_source_addr, in_dest_addr, in_source_port, in_dest_port,
                           in_sequence_number, in_flag_bits, in_window_size);
        for (int i = 0; i < 10; i++) begin
          expected_words.push_back('{word: hdr[i], idx: 4'(i), last: (i == 9)});
        end
      end
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          $display("%0t unexpected word: expected none, got %h idx %0d last %0d",
                   $time, out_header_word, out_word_index, out_last_word);
          err_count++;
        end else begin
          exp_beat = expected_words.pop_front();
          if (out_header_word !== exp_beat.word) begin
            $display("%0t header_word mismatch at idx %0d: expected %h, got %h",
                     $time, exp_beat.idx, exp_beat.word, out_header_word);
            err_count++;
          end
          if (out_word_index !== exp_beat.idx) begin
            $display("%0t word_index mismatch: expected %0d, got %0d",
                     $time, exp_beat.idx, out_word_index);
            err_count++;
          end
          if (out_last_word !== exp_beat.last) begin
            $display("%0t last_word mismatch at idx %0d: expected %0d, got %0d",
                     $time, exp_beat.idx, exp_beat.last, out_last_word);
            err_count++;
          end
        end
      end
    end
    pending = expected_words.size();
  end

endmodule

`default_nettype wire

// ===== test/tb_tcp_syn_packet_builder.sv =====
// ----------------------------------------------------------------------------
// tb_tcp_syn_packet_builder
// Stimulus and verdict for the IPv4/TCP SYN header builder.
// ----------------------------------------------------------------------------
// A directed part covers field extremes, each TCP flag alone, zero window
// (also with a zero default), checksums that come out zero and config
// writes with stray high bits or an unused index. A random part follows in
// segments, each preceded by a config change while the block is idle.
// Both sides idle at random per word; some segments run with no idling.
// Checking lives in tsyn_checker, which hands back a failure count.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_tcp_syn_packet_builder;
  import tsyn_pkg::*;

  localparam logic [1:0] CFG_UNUSED = 2'd3;  // not a register; writes are dropped
  localparam int         LIMIT      = 250000;
  localparam int         TAIL       = 12;    // pipeline is four deep plus slack
  localparam int         SEG_ITEMS  = 25;
  localparam int         SEG_COUNT  = 8;

  typedef struct packed {
    logic [31:0] src;
    logic [31:0] dst;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [31:0] seq;
    logic [5:0]  flg;
    logic [15:0] win;
  } syn_req_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] in_source_addr = '0;
  logic [31:0] in_dest_addr = '0;
  logic [15:0] in_source_port = '0;
  logic [15:0] in_dest_port = '0;
  logic [31:0] in_sequence_number = '0;
  logic [5:0]  in_flag_bits = '0;
  logic [15:0] in_window_size = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_header_word;
  logic [3:0]  out_word_index;
  logic        out_last_word;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  int          err_count;
  int          pending;
  int          cycle_cnt = 0;
  bit          calm = 1'b0;      // when set, neither side idles
  bit          rx_took = 1'b0;   // a word was taken at the last rising edge
  int unsigned rx_gap = 0;

  always #2 clk = ~clk;

  tcp_syn_packet_builder u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_source_addr     (in_source_addr),
    .in_dest_addr       (in_dest_addr),
    .in_source_port     (in_source_port),
    .in_dest_port       (in_dest_port),
    .in_sequence_number (in_sequence_number),
    .in_flag_bits       (in_flag_bits),
    .in_window_size     (in_window_size),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_header_word    (out_header_word),
    .out_word_index     (out_word_index),
    .out_last_word      (out_last_word),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  tsyn_checker u_chk (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_source_addr     (in_source_addr),
    .in_dest_addr       (in_dest_addr),
    .in_source_port     (in_source_port),
    .in_dest_port       (in_dest_port),
    .in_sequence_number (in_sequence_number),
    .in_flag_bits       (in_flag_bits),
    .in_window_size     (in_window_size),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_header_word    (out_header_word),
    .out_word_index     (out_word_index),
    .out_last_word      (out_last_word),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .err_count          (err_count),
    .pending            (pending)
  );

  // watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic int unsigned draw_gap();
    if (calm) return 0;
    return $urandom_range(0, 17);
  endfunction

  // Receiver: after every taken word, hold ready low for a drawn number of
  // cycles. The handshake is sampled at the rising edge, ready driven at
  // the falling edge.
  always @(posedge clk) rx_took <= out_valid && out_ready;

  always @(negedge clk) begin
    if (rx_took) rx_gap = draw_gap();
    if (rx_gap != 0) begin
      out_ready <= 1'b0;
      rx_gap = rx_gap - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // One request word. Valid stays high after acceptance until the next call
  // or rest_input lowers it; between requests it drops only for a drawn gap.
  task automatic send_req(input syn_req_t r);
    int unsigned gap;
    gap = draw_gap();
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid           <= 1'b1;
    in_source_addr     <= r.src;
    in_dest_addr       <= r.dst;
    in_source_port     <= r.sport;
    in_dest_port       <= r.dport;
    in_sequence_number <= r.seq;
    in_flag_bits       <= r.flg;
    in_window_size     <= r.win;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic rest_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Stop sending and wait until every expected word has come out.
  task automatic drain();
    rest_input();
    while (pending != 0) @(negedge clk);
    repeat (TAIL) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [15:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic syn_req_t random_req();
    syn_req_t r;
    r.src   = $urandom();
    r.dst   = $urandom();
    r.sport = 16'($urandom());
    r.dport = 16'($urandom());
    r.seq   = $urandom();
    r.flg   = 6'($urandom_range(0, 63));
    r.win   = ($urandom_range(0, 5) == 0) ? 16'd0 : 16'($urandom());
    if ($urandom_range(0, 11) == 0) r = '1;
    return r;
  endfunction

  function automatic syn_req_t mk_req(input logic [31:0] src, input logic [31:0] seq,
                                      input logic [5:0] flg, input logic [15:0] win);
    syn_req_t r;
    r       = random_req();
    r.src   = src;
    r.dst   = 32'd0;
    r.sport = 16'd0;
    r.dport = 16'd0;
    r.seq   = seq;
    r.flg   = flg;
    r.win   = win;
    return r;
  endfunction

  initial begin
    syn_req_t r;
    logic [15:0] d;

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // --- directed, reset config ---
    send_req('0);                 // zero window -> default 0xFFFF
    send_req('1);
    for (int i = 0; i < 6; i++) begin
      r     = random_req();
      r.flg = 6'(1 << i);
      send_req(r);
    end
    // IP checksum of zero with ident 54321 and ttl 64
    send_req(mk_req(32'hA69F_0000, 32'd0, 6'd0, 16'd7));
    // TCP checksum of zero, independent of the config
    send_req(mk_req(32'd0, 32'h0000_AFE4, 6'd0, 16'd1));
    drain();

    // --- low extremes; ttl write carries stray high bits ---
    cfg_write(CFG_IP_IDENT, 16'h0000);
    cfg_write(CFG_TTL, 16'hFF00);
    cfg_write(CFG_DEF_WIN, 16'h0000);
    cfg_write(CFG_UNUSED, 16'hFFFF);
    send_req(mk_req(32'h1234_5678, 32'h8765_4321, 6'h3F, 16'd0));  // zero default
    send_req(mk_req(32'hBAD1_0000, 32'd0, 6'd0, 16'd9));           // IP checksum zero
    send_req('0);
    send_req('1);
    drain();

    // --- high extremes, no idling ---
    calm = 1'b1;
    cfg_write(CFG_IP_IDENT, 16'hFFFF);
    cfg_write(CFG_TTL, 16'h00FF);
    cfg_write(CFG_DEF_WIN, 16'hFFFF);
    cfg_write(CFG_UNUSED, 16'h0000);
    send_req(mk_req(32'hBBD0_0000, 32'd0, 6'd2, 16'd3));           // IP checksum zero
    send_req('0);
    send_req('1);
    send_req(random_req());
    send_req(random_req());
    drain();

    // --- random segments, each with its own config ---
    for (int s = 0; s < SEG_COUNT; s++) begin
      calm = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < 3; k++) begin
        case ($urandom_range(0, 3))
          0:       d = 16'h0000;
          1:       d = 16'hFFFF;
          default: d = 16'($urandom());
        endcase
        cfg_write(2'(k), d);
      end
      if ($urandom_range(0, 2) == 0) cfg_write(CFG_UNUSED, 16'($urandom()));
      for (int n = 0; n < SEG_ITEMS; n++) begin
        send_req(random_req());
        // now and then let the block run dry mid-segment
        if ($urandom_range(0, 29) == 0) drain();
      end
      drain();
    end

    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
